FILE: design/jfs_pkg.sv
// Package for the JPEG frame size scanner.
// Holds the scan phase type, marker byte codes and the result struct.
// No dependencies.
package jfs_pkg;

   // Marker byte codes
   localparam logic [7:0] BYTE_MARKER = 8'hFF;
   localparam logic [7:0] MARK_SOF0   = 8'hC0;
   localparam logic [7:0] MARK_SOF1   = 8'hC1;
   localparam logic [7:0] MARK_SOF2   = 8'hC2;
   localparam logic [7:0] MARK_RST0   = 8'hD0;
   localparam logic [7:0] MARK_EOI    = 8'hD9;

   // Bytes after an SOF marker before the height: length high, length low, precision
   localparam logic [15:0] SOF_PREFIX_LEN = 16'd3;
   // A segment length counts its own two bytes
   localparam logic [15:0] SEG_LEN_BYTES  = 16'd2;

   // Byte walk phases, one-hot
   typedef enum logic [12:0] {
      PH_SKIP0   = 13'b0000000000001,
      PH_SKIP1   = 13'b0000000000010,
      PH_SCAN    = 13'b0000000000100,
      PH_MARKER  = 13'b0000000001000,
      PH_LENHI   = 13'b0000000010000,
      PH_LENLO   = 13'b0000000100000,
      PH_SEGSKIP = 13'b0000001000000,
      PH_SOFPRE  = 13'b0000010000000,
      PH_HHI     = 13'b0000100000000,
      PH_HLO     = 13'b0001000000000,
      PH_WHI     = 13'b0010000000000,
      PH_WLO     = 13'b0100000000000,
      PH_DONE    = 13'b1000000000000
   } phase_type;

   // One result item from the scanner
   typedef struct packed {
      logic        valid;
      logic        found;
      logic [15:0] height;
      logic [15:0] width;
   } result_type;

endpackage

FILE: design/jfs_scan.sv
// Per-byte scan state machine of the JPEG frame size scanner.
// Holds the walk state and builds the result for the byte in the input register.
// Depends on jfs_pkg.
module jfs_scan
   import jfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   output result_type  result
);

   phase_type   phase_ff,        phase_in;
   logic [15:0] byte_count_ff,   byte_count_in;
   logic [15:0] height_ff,       height_in;
   logic [7:0]  width_high_ff,   width_high_in;
   logic [7:0]  length_high_ff,  length_high_in;
   logic        reported_ff,     reported_in;

   logic [15:0] seg_len;
   logic [15:0] count_dec;

   assign seg_len   = {length_high_ff, data_byte};
   assign count_dec = byte_count_ff - 16'd1;

   // Advance the byte walk and form the result
   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      height_in      = height_ff;
      width_high_in  = width_high_ff;
      length_high_in = length_high_ff;
      reported_in    = reported_ff;
      result         = '0;

      unique case (phase_ff)
         PH_SKIP0: begin
            phase_in = PH_SKIP1;
         end
         PH_SKIP1: begin
            phase_in = PH_SCAN;
         end
         PH_MARKER: begin
            case (data_byte) inside
               MARK_SOF0, MARK_SOF1, MARK_SOF2: begin
                  byte_count_in = SOF_PREFIX_LEN;
                  phase_in      = PH_SOFPRE;
               end
               [MARK_RST0:MARK_EOI]: begin
                  phase_in = PH_SCAN;
               end
               default: begin
                  phase_in = PH_LENHI;
               end
            endcase
         end
         PH_LENHI: begin
            length_high_in = data_byte;
            phase_in       = PH_LENLO;
         end
         PH_LENLO: begin
            if (seg_len <= SEG_LEN_BYTES) begin
               phase_in = PH_SCAN;
            end else begin
               byte_count_in = seg_len - SEG_LEN_BYTES;
               phase_in      = PH_SEGSKIP;
            end
         end
         PH_SEGSKIP: begin
            byte_count_in = count_dec;
            if (count_dec == 16'd0) begin
               phase_in = PH_SCAN;
            end
         end
         PH_SOFPRE: begin
            byte_count_in = count_dec;
            if (count_dec == 16'd0) begin
               phase_in = PH_HHI;
            end
         end
         PH_HHI: begin
            height_in = {data_byte, 8'd0};
            phase_in  = PH_HLO;
         end
         PH_HLO: begin
            height_in = {height_ff[15:8], height_ff[7:0] | data_byte};
            phase_in  = PH_WHI;
         end
         PH_WHI: begin
            width_high_in = data_byte;
            phase_in      = PH_WLO;
         end
         PH_WLO: begin
            result.valid  = 1'b1;
            result.found  = 1'b1;
            result.height = height_ff;
            result.width  = {width_high_ff, data_byte};
            reported_in   = 1'b1;
            phase_in      = PH_DONE;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            // scan phase and any stray code
            phase_in = (data_byte == BYTE_MARKER) ? PH_MARKER : PH_SCAN;
         end
      endcase

      // End of file: report not found once, then clear for the next file
      if (last_byte) begin
         if (!result.valid && !reported_ff) begin
            result.valid = 1'b1;
         end
         phase_in       = PH_SKIP0;
         byte_count_in  = '0;
         height_in      = '0;
         width_high_in  = '0;
         length_high_in = '0;
         reported_in    = 1'b0;
      end
   end

   // Hold the walk state, update on each stepped byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SKIP0;
         byte_count_ff  <= '0;
         height_ff      <= '0;
         width_high_ff  <= '0;
         length_high_ff <= '0;
         reported_ff    <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         height_ff      <= height_in;
         width_high_ff  <= width_high_in;
         length_high_ff <= length_high_in;
         reported_ff    <= reported_in;
      end
   end

endmodule

FILE: design/jpeg_frame_size_scanner_top.sv
// A byte's result passes through the input register and then the result register.
// One byte per cycle while the result side does not stall; the scan state machine steps once per byte.
// A result register and the input register let a byte enter while a result waits.
// Reset is synchronous, active high: walk state returns to skipping the first two bytes.
// Top level of the JPEG frame size scanner; instantiates jfs_scan, uses jfs_pkg.
module jpeg_frame_size_scanner_top
   import jfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [15:0] rsp_height,
   output logic [15:0] rsp_width
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_valid_ff, out_valid_in;
   logic        out_found_ff;
   logic [15:0] out_height_ff;
   logic [15:0] out_width_ff;

   logic        advance;
   logic        step;
   logic        accept;
   result_type  result;

   // Result register free or draining this cycle
   assign advance     = !out_valid_ff || !rsp_stall;
   assign step        = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = req_stall ? 1'b1 : req_valid;
   assign out_valid_in = step && result.valid;

   jfs_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   // Input register: hold while stalled, load on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_in) begin
         out_found_ff  <= result.found;
         out_height_ff <= result.height;
         out_width_ff  <= result.width;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_found  = out_found_ff;
   assign rsp_height = out_height_ff;
   assign rsp_width  = out_width_ff;

endmodule

FILE: tb/jpeg_frame_size_scanner_top_tb.sv
// Testbench for jpeg_frame_size_scanner_top: streams JPEG-like byte files and checks
// the reported frame sizes against a built-in scan predictor.
// Depends on jfs_pkg (marker codes, phase enum) and the scanner RTL only.
module jpeg_frame_size_scanner_top_tb
   import jfs_pkg::*;
();

   localparam logic [7:0] SOI_BYTE  = 8'hD8;
   localparam logic [7:0] APP0_BYTE = 8'hE0;
   localparam logic [7:0] APP1_BYTE = 8'hE1;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic        found;
      logic [15:0] height;
      logic [15:0] width;
   } frame_dims_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [15:0] rsp_height;
   logic [15:0] rsp_width;

   // Predictor state
   phase_type   walk_ph;
   logic [15:0] skip_left;
   logic [15:0] hgt_acc;
   logic [7:0]  wid_hi;
   logic [7:0]  seglen_hi;
   logic        dims_reported;

   frame_dims_type dims_expect_q[$];
   logic [7:0]     file_q[$];

   int in_idle_pct = 25;
   int out_idle_pct = 25;
   int cycle_no = 0;
   int hold_until = 0;
   int fail_count = 0;
   int items_sent = 0;
   int files_sent = 0;
   int results_checked = 0;
   int found_seen = 0;

   jpeg_frame_size_scanner_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_height    (rsp_height),
      .rsp_width     (rsp_width)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clear the walk for the next file
   function automatic void clear_scan_state();
      walk_ph       = PH_SKIP0;
      skip_left     = '0;
      hgt_acc       = '0;
      wid_hi        = '0;
      seglen_hi     = '0;
      dims_reported = 1'b0;
   endfunction

   // Advance the walk by one byte and queue any frame size it yields
   function automatic void predict_scan_byte(input logic [7:0] b, input logic last);
      logic [15:0] seg_len;
      logic        emitted;
      emitted = 1'b0;
      case (walk_ph)
         PH_SKIP0: walk_ph = PH_SKIP1;
         PH_SKIP1: walk_ph = PH_SCAN;
         PH_MARKER: begin
            if (b == MARK_SOF0 || b == MARK_SOF1 || b == MARK_SOF2) begin
               skip_left = SOF_PREFIX_LEN;
               walk_ph   = PH_SOFPRE;
            end else if (b >= MARK_RST0 && b <= MARK_EOI) begin
               walk_ph = PH_SCAN;
            end else begin
               walk_ph = PH_LENHI;
            end
         end
         PH_LENHI: begin
            seglen_hi = b;
            walk_ph   = PH_LENLO;
         end
         PH_LENLO: begin
            seg_len = {seglen_hi, b};
            if (seg_len <= SEG_LEN_BYTES) begin
               walk_ph = PH_SCAN;
            end else begin
               skip_left = seg_len - SEG_LEN_BYTES;
               walk_ph   = PH_SEGSKIP;
            end
         end
         PH_SEGSKIP: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 16'd0) walk_ph = PH_SCAN;
         end
         PH_SOFPRE: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 16'd0) walk_ph = PH_HHI;
         end
         PH_HHI: begin
            hgt_acc = {b, 8'h00};
            walk_ph = PH_HLO;
         end
         PH_HLO: begin
            hgt_acc = hgt_acc | {8'h00, b};
            walk_ph = PH_WHI;
         end
         PH_WHI: begin
            wid_hi  = b;
            walk_ph = PH_WLO;
         end
         PH_WLO: begin
            dims_expect_q.push_back('{found: 1'b1, height: hgt_acc, width: {wid_hi, b}});
            emitted       = 1'b1;
            dims_reported = 1'b1;
            walk_ph       = PH_DONE;
         end
         PH_DONE: ;
         default: walk_ph = (b == BYTE_MARKER) ? PH_MARKER : PH_SCAN;
      endcase
      if (last) begin
         if (!emitted && !dims_reported)
            dims_expect_q.push_back('{found: 1'b0, height: 16'h0000, width: 16'h0000});
         clear_scan_state();
      end
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   // Mostly plain values, with the extremes now and then
   function automatic logic [15:0] rand_dim();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return r[15:0];
      endcase
   endfunction

   // Build a mostly well-formed file: header, some segments and fill, usually an SOF, a tail
   function automatic void build_jpeg_file();
      int          seg_len;
      int          pick;
      logic [7:0]  mark;
      logic [15:0] hgt;
      logic [15:0] wid;
      file_q.delete();
      if ($urandom_range(9) == 0) begin
         file_q.push_back(rand_byte());
         file_q.push_back(rand_byte());
      end else begin
         file_q.push_back(BYTE_MARKER);
         file_q.push_back(SOI_BYTE);
      end
      repeat ($urandom_range(4)) begin
         pick = $urandom_range(9);
         if (pick < 3) begin
            file_q.push_back(BYTE_MARKER);
            file_q.push_back(MARK_RST0 + 8'($urandom_range(9)));
         end else if (pick < 8) begin
            // Pick a marker that carries a length
            if ($urandom_range(9) == 0) begin
               mark = BYTE_MARKER;
            end else begin
               do mark = rand_byte();
               while ((mark >= MARK_SOF0 && mark <= MARK_SOF2) ||
                      (mark >= MARK_RST0 && mark <= MARK_EOI));
            end
            pick = $urandom_range(19);
            if (pick < 3) seg_len = pick;
            else if (pick == 19 && $urandom_range(3) == 0) seg_len = $urandom_range(256, 600);
            else seg_len = $urandom_range(3, 12);
            file_q.push_back(BYTE_MARKER);
            file_q.push_back(mark);
            file_q.push_back(8'(seg_len >> 8));
            file_q.push_back(8'(seg_len));
            if (seg_len > 2)
               repeat (seg_len - 2) file_q.push_back(rand_byte());
         end else begin
            // Fill bytes that never start a marker
            repeat ($urandom_range(1, 3)) begin
               do mark = rand_byte();
               while (mark == BYTE_MARKER);
               file_q.push_back(mark);
            end
         end
      end
      if ($urandom_range(4) != 0) begin
         hgt = rand_dim();
         wid = rand_dim();
         file_q.push_back(BYTE_MARKER);
         file_q.push_back(MARK_SOF0 + 8'($urandom_range(2)));
         if ($urandom_range(3) == 0) begin
            file_q.push_back(rand_byte());
            file_q.push_back(rand_byte());
            file_q.push_back(rand_byte());
         end else begin
            file_q.push_back(8'h00);
            file_q.push_back(8'h11);
            file_q.push_back(8'h08);
         end
         file_q.push_back(hgt[15:8]);
         file_q.push_back(hgt[7:0]);
         file_q.push_back(wid[15:8]);
         file_q.push_back(wid[7:0]);
         repeat ($urandom_range(9)) file_q.push_back(rand_byte());
      end
      if ($urandom_range(1) == 0) begin
         file_q.push_back(BYTE_MARKER);
         file_q.push_back(MARK_EOI);
      end
   endfunction

   // Build a short file of noise, rich in marker-like bytes
   function automatic void build_noise_file();
      int pick;
      file_q.delete();
      repeat ($urandom_range(1, 30)) begin
         pick = $urandom_range(9);
         if (pick < 3) file_q.push_back(BYTE_MARKER);
         else if (pick == 3) file_q.push_back(MARK_SOF0 + 8'($urandom_range(2)));
         else if (pick == 4) file_q.push_back(MARK_RST0 + 8'($urandom_range(9)));
         else file_q.push_back(rand_byte());
      end
   endfunction

   // Offer one byte, idling at random first, and hold it until the transfer
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < in_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_scan_byte(b, last);
      items_sent++;
   endtask

   task automatic send_file();
      int i;
      for (i = 0; i < file_q.size(); i++)
         send_byte(file_q[i], i == file_q.size() - 1);
      files_sent++;
   endtask

   // Stop offering and hold until every expected frame size has arrived
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (dims_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic flag_result_error(input string why, input frame_dims_type want);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0d: %s: expected found=%0b h=%0d w=%0d, got found=%0b h=%0d w=%0d",
                  cycle_no, why, want.found, want.height, want.width,
                  rsp_found, rsp_height, rsp_width);
   endtask

   // Result side: stall at random or during a hold-off, check each transfer
   always @(posedge clock) begin : rsp_check
      frame_dims_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_no++;
         if (rsp_valid && !rsp_stall) begin
            if (dims_expect_q.size() == 0) begin
               flag_result_error("unexpected result", '0);
            end else begin
               want = dims_expect_q.pop_front();
               results_checked++;
               if (rsp_found === 1'b1) found_seen++;
               if (rsp_found !== want.found || rsp_height !== want.height ||
                   rsp_width !== want.width)
                  flag_result_error("result mismatch", want);
            end
         end
         rsp_stall <= (cycle_no < hold_until) || ($urandom_range(99) < out_idle_pct);
      end
   end

   // SOF0, SOF1 and SOF2 headers, extreme sizes, bytes after the result
   task automatic test_found_headers();
      file_q = '{BYTE_MARKER, SOI_BYTE, BYTE_MARKER, MARK_SOF0, 8'h00, 8'h11, 8'h08,
                 8'h12, 8'h34, 8'h56, 8'h78, 8'h03, BYTE_MARKER, MARK_EOI};
      send_file();
      // Last byte carries the width's low byte
      file_q = '{BYTE_MARKER, SOI_BYTE, BYTE_MARKER, MARK_SOF1, 8'h00, 8'h11, 8'h08,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_file();
      file_q = '{8'h00, 8'h00, BYTE_MARKER, MARK_SOF2, 8'hFF, 8'hFF, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_file();
      wait_results_drained();
   endtask

   // Standalone markers, marker after marker, segment lengths below and at two
   task automatic test_marker_handling();
      file_q = '{BYTE_MARKER, SOI_BYTE, BYTE_MARKER, MARK_RST0, BYTE_MARKER, MARK_EOI,
                 BYTE_MARKER, BYTE_MARKER, 8'h00, 8'h04, 8'hAA, 8'hBB,
                 BYTE_MARKER, APP0_BYTE, 8'h00, 8'h01,
                 BYTE_MARKER, APP1_BYTE, 8'h00, 8'h02, 8'h00,
                 BYTE_MARKER, MARK_SOF0, 8'h00, 8'h11, 8'h08, 8'h01, 8'hE0, 8'h02, 8'h80,
                 BYTE_MARKER, MARK_EOI};
      send_file();
      wait_results_drained();
   endtask

   // One-byte file, file cut in a segment, file cut in an SOF header
   task automatic test_not_found();
      file_q = '{SOI_BYTE};
      send_file();
      file_q = '{BYTE_MARKER, SOI_BYTE, BYTE_MARKER, APP0_BYTE, 8'h00, 8'h05};
      send_file();
      file_q = '{BYTE_MARKER, SOI_BYTE, BYTE_MARKER, MARK_SOF0, 8'h00, 8'h11, 8'h08, 8'h12};
      send_file();
      wait_results_drained();
   endtask

   // Hold off the result side while one-byte files keep coming, so input backs up
   task automatic test_backpressure();
      in_idle_pct  = 0;
      out_idle_pct = 0;
      hold_until   = cycle_no + 64;
      repeat (24) begin
         file_q.delete();
         file_q.push_back(rand_byte());
         send_file();
      end
      wait_results_drained();
      in_idle_pct  = 25;
      out_idle_pct = 25;
   endtask

   // Mostly well-formed files with random content, plus cut and noise files
   task automatic test_random_files();
      int first_item;
      int progress;
      int pick;
      int cut;
      first_item = items_sent;
      while (items_sent - first_item < 2000) begin
         progress = items_sent - first_item;
         // Run a long stretch with no idling on either side
         if (progress >= 700 && progress < 1200) begin
            in_idle_pct  = 0;
            out_idle_pct = 0;
         end else begin
            in_idle_pct  = 25;
            out_idle_pct = 25;
         end
         pick = $urandom_range(99);
         if (pick < 75) begin
            build_jpeg_file();
         end else if (pick < 88) begin
            build_jpeg_file();
            cut = $urandom_range(1, file_q.size());
            while (file_q.size() > cut) void'(file_q.pop_back());
         end else begin
            build_noise_file();
         end
         send_file();
      end
      wait_results_drained();
   endtask

   initial begin
      clear_scan_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_found_headers();
      test_marker_handling();
      test_not_found();
      test_backpressure();
      test_random_files();
      $display("Sent %0d bytes in %0d files; checked %0d results, %0d with a frame size.",
               items_sent, files_sent, results_checked, found_seen);
      $display("Mismatches and unexpected results: %0d.", fail_count);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Bound the run
   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding.", dims_expect_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
